/* src/ewts_pkg.sv */
package ewts_pkg;

   localparam int NODES = 16;
   localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int ADDR_W = $clog2(NODES * NODES);
   localparam int EMIT_COUNT = (NODES < 16) ? NODES : 16;
   localparam int CSR_ADDR_W = 8;

   localparam logic [1:0] MODE_MATRIX = 2'd0;
   localparam logic [1:0] MODE_DISP = 2'd1;
   localparam logic [1:0] MODE_STEP = 2'd2;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_LIMIT = 2'd1;
   localparam logic [1:0] STATUS_SAT = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_TIME_STEP = 8'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_STEP_LIMIT = 8'd1;

   localparam logic [15:0] TIME_STEP_RESET = 16'd655;
   localparam logic [15:0] STEP_LIMIT_RESET = 16'd100;

   typedef struct packed {
      logic shift;
      logic rotate;
   } cell_ctrl_type;

endpackage

/* src/ewts_if.sv */
interface ewts_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [3:0]  row;
   logic [3:0]  col;
   logic signed [31:0] value;
   modport source (output valid, mode, row, col, value, input ready);
   modport sink (input valid, mode, row, col, value, output ready);
endinterface

interface ewts_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] step_number;
   logic [3:0]  node;
   logic signed [31:0] displacement;
   logic [31:0] time_value;
   logic [1:0]  status;
   logic        last;
   modport source (output valid, step_number, node, displacement, time_value, status, last,
                   input ready);
   modport sink (input valid, step_number, node, displacement, time_value, status, last,
                 output ready);
endinterface

interface ewts_csr_if;
   logic        valid;
   logic        ready;
   logic [ewts_pkg::CSR_ADDR_W-1:0] addr;
   logic [15:0] data;
   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

/* src/ewts_ram.sv */
module ewts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/ewts_cell.sv */
module ewts_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  ewts_pkg::cell_ctrl_type ctrl,
   input  logic signed [31:0]     neighbor_cur,
   input  logic                   load_sel,
   input  logic signed [31:0]     load_value,
   input  logic                   fin_sel,
   input  logic signed [31:0]     fin_value,
   input  logic                   fin_sat,
   output logic signed [31:0]     cur,
   output logic signed [31:0]     prev,
   output logic                   sat
);

   logic signed [31:0] cur_ff, prev_ff, nxt_ff;
   logic               sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
         prev_ff <= '0;
         nxt_ff <= '0;
      end else begin
         if (load_sel) begin
            cur_ff <= load_value;
         end else if (ctrl.shift) begin
            cur_ff <= neighbor_cur;
         end else if (ctrl.rotate) begin
            prev_ff <= cur_ff;
            cur_ff <= nxt_ff;
         end
         if (fin_sel) begin
            nxt_ff <= fin_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fin_sel) begin
         sat_ff <= fin_sat;
      end
   end

   assign cur = cur_ff;
   assign prev = prev_ff;
   assign sat = sat_ff;

endmodule

/* src/ewts_mac.sv */
module ewts_mac (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic signed [31:0] a,
   input  logic signed [31:0] u,
   input  logic               clear,
   output logic signed [63:0] acc,
   output logic               busy
);

   logic signed [63:0] prod_ff;
   logic signed [47:0] rnd_ff;
   logic signed [63:0] acc_ff;
   logic               prod_vld_ff, rnd_vld_ff;
   logic [63:0]        mag;
   logic [63:0]        mag_rnd;
   logic signed [47:0] rnd_in;

   always_comb begin
      mag = prod_ff[63] ? (64'd0 - 64'(prod_ff)) : 64'(prod_ff);
      mag_rnd = (mag + 64'h8000) >> 16;
      rnd_in = prod_ff[63] ? -$signed(mag_rnd[47:0]) : $signed(mag_rnd[47:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         rnd_vld_ff <= 1'b0;
         acc_ff <= '0;
      end else begin
         prod_vld_ff <= in_valid;
         rnd_vld_ff <= prod_vld_ff;
         if (clear) begin
            acc_ff <= '0;
         end else if (rnd_vld_ff) begin
            acc_ff <= acc_ff + 64'(rnd_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= a * u;
      rnd_ff <= rnd_in;
   end

   assign acc = acc_ff;
   assign busy = prod_vld_ff | rnd_vld_ff;

endmodule

/* src/explicit_wave_time_step_core.sv */
// Load transactions (matrix entry, displacement) are accepted only in S_IDLE.
// A step transaction's compute is set by the single shared multiply-accumulate that walks
// the displacement ring once per row, then EMIT_COUNT results are emitted as the response
// bus accepts them; a limit-reached step gives its one result, with status LIMIT.
// Reset (synchronous, active high) clears displacements, step count and the config registers
// to dt=655 and limit=100; matrix contents are undefined until written.
module explicit_wave_time_step_core (
   input  logic clock,
   input  logic reset,
   ewts_req_if.sink   req_bus,
   ewts_rsp_if.source rsp_bus,
   ewts_csr_if.sink   csr_bus
);

   localparam int N = ewts_pkg::NODES;
   localparam int IW = ewts_pkg::IDX_W;
   localparam int AW = ewts_pkg::ADDR_W;

   typedef enum logic [3:0] {
      S_IDLE, S_START, S_MAC, S_WAIT, S_SMAG, S_SMUL, S_SSUM, S_FIN, S_ROTATE, S_EMIT
   } state_type;

   state_type state_ff;
   logic [15:0] time_step_ff, step_limit_ff, steps_done_ff;
   logic [31:0] d2_ff, tv_ff;
   logic        first_ff;
   logic [IW-1:0] row_ff, col_ff, node_ff;
   logic        issue_ff;
   logic signed [31:0] u_q_ff;
   logic        neg_ff;
   logic [63:0] mag_ff, hp_ff, lp_ff;
   logic signed [65:0] sc_ff;

   logic        rsp_valid_ff, rsp_last_ff;
   logic [15:0] rsp_step_ff;
   logic [3:0]  rsp_node_ff;
   logic signed [31:0] rsp_disp_ff;
   logic [31:0] rsp_time_ff;
   logic [1:0]  rsp_status_ff;

   logic        req_fire, rsp_free;
   logic        ram_wr_en;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   logic [31:0] ram_rd_data;
   logic signed [63:0] acc;
   logic        mac_busy, mac_clear;

   ewts_pkg::cell_ctrl_type cell_ctrl;
   logic signed [31:0] cell_cur [N];
   logic signed [31:0] cell_prev [N];
   logic        cell_sat [N];
   logic        load_sel [N];
   logic        fin_sel [N];
   logic [IW-1:0] rd_idx;
   logic signed [31:0] sel_cur, sel_prev;
   logic        sel_sat;
   logic        disp_load;
   logic signed [33:0] base;
   logic signed [66:0] nx;
   logic signed [31:0] fin_value;
   logic        fin_sat;
   logic [64:0] r_sum;

   assign req_fire = req_bus.valid & req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE) & ~rsp_valid_ff;
   assign csr_bus.ready = 1'b1;
   assign rsp_free = ~rsp_valid_ff | rsp_bus.ready;

   assign ram_wr_en = req_fire & (req_bus.mode == ewts_pkg::MODE_MATRIX)
                      & (32'(req_bus.row) < N) & (32'(req_bus.col) < N);
   assign ram_wr_addr = AW'(32'(req_bus.row) * N + 32'(req_bus.col));
   assign ram_rd_addr = AW'(32'(row_ff) * N + 32'(col_ff));
   assign disp_load = req_fire & (req_bus.mode == ewts_pkg::MODE_DISP) & (32'(req_bus.row) < N);

   ewts_ram #(.WIDTH(32), .DEPTH(N * N)) u_matrix (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_bus.value),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign mac_clear = (state_ff == S_START) | (state_ff == S_FIN);

   ewts_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .in_valid (issue_ff),
      .a        ($signed(ram_rd_data)),
      .u        (u_q_ff),
      .clear    (mac_clear),
      .acc      (acc),
      .busy     (mac_busy)
   );

   assign cell_ctrl.shift = (state_ff == S_MAC);
   assign cell_ctrl.rotate = (state_ff == S_ROTATE);

   assign rd_idx = (state_ff == S_EMIT) ? node_ff : row_ff;
   assign sel_cur = cell_cur[rd_idx];
   assign sel_prev = cell_prev[rd_idx];
   assign sel_sat = cell_sat[rd_idx];

   always_comb begin
      base = first_ff ? 34'(sel_cur) : (34'(sel_cur) <<< 1) - 34'(sel_prev);
      nx = 67'(sc_ff) + 67'(base);
      if (nx > 67'sd2147483647) begin
         fin_value = 32'sh7fffffff;
         fin_sat = 1'b1;
      end else if (nx < -67'sd2147483648) begin
         fin_value = 32'sh80000000;
         fin_sat = 1'b1;
      end else begin
         fin_value = nx[31:0];
         fin_sat = 1'b0;
      end
      r_sum = 65'(hp_ff) + 65'((65'(lp_ff) + 65'h80000000) >> 32);
   end

   for (genvar c = 0; c < N; c++) begin : g_cell
      assign load_sel[c] = disp_load & (IW'(req_bus.row) == IW'(c));
      assign fin_sel[c] = (state_ff == S_FIN) & (row_ff == IW'(c));
      ewts_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (cell_ctrl),
         .neighbor_cur (cell_cur[(c + 1) % N]),
         .load_sel     (load_sel[c]),
         .load_value   (req_bus.value),
         .fin_sel      (fin_sel[c]),
         .fin_value    (fin_value),
         .fin_sat      (fin_sat),
         .cur          (cell_cur[c]),
         .prev         (cell_prev[c]),
         .sat          (cell_sat[c])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         time_step_ff <= ewts_pkg::TIME_STEP_RESET;
         step_limit_ff <= ewts_pkg::STEP_LIMIT_RESET;
         steps_done_ff <= '0;
         rsp_valid_ff <= 1'b0;
         issue_ff <= 1'b0;
         row_ff <= '0;
         col_ff <= '0;
         node_ff <= '0;
      end else begin
         issue_ff <= (state_ff == S_MAC);
         if (rsp_valid_ff & rsp_bus.ready & ~((state_ff == S_EMIT) & rsp_free)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_bus.valid) begin
            if (csr_bus.addr == ewts_pkg::CSR_TIME_STEP) begin
               time_step_ff <= csr_bus.data;
            end else if (csr_bus.addr == ewts_pkg::CSR_STEP_LIMIT) begin
               step_limit_ff <= csr_bus.data;
            end
         end
         case (state_ff)
            S_IDLE: begin
               if (disp_load) begin
                  steps_done_ff <= '0;
               end
               if (req_fire & (req_bus.mode == ewts_pkg::MODE_STEP)) begin
                  if (steps_done_ff >= step_limit_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_step_ff <= steps_done_ff;
                     rsp_node_ff <= '0;
                     rsp_disp_ff <= '0;
                     rsp_time_ff <= time_step_ff * steps_done_ff;
                     rsp_status_ff <= ewts_pkg::STATUS_LIMIT;
                     rsp_last_ff <= 1'b1;
                  end else begin
                     state_ff <= S_START;
                  end
               end
            end
            S_START: begin
               d2_ff <= time_step_ff * time_step_ff;
               first_ff <= (steps_done_ff == '0);
               steps_done_ff <= steps_done_ff + 16'd1;
               row_ff <= '0;
               col_ff <= '0;
               state_ff <= S_MAC;
            end
            S_MAC: begin
               u_q_ff <= cell_cur[0];
               col_ff <= col_ff + IW'(1);
               if (col_ff == IW'(N - 1)) begin
                  state_ff <= S_WAIT;
               end
            end
            S_WAIT: begin
               if (~issue_ff & ~mac_busy) begin
                  state_ff <= S_SMAG;
               end
            end
            S_SMAG: begin
               neg_ff <= acc[63];
               mag_ff <= acc[63] ? (64'd0 - 64'(acc)) : 64'(acc);
               state_ff <= S_SMUL;
            end
            S_SMUL: begin
               hp_ff <= mag_ff[63:32] * d2_ff;
               lp_ff <= mag_ff[31:0] * d2_ff;
               state_ff <= S_SSUM;
            end
            S_SSUM: begin
               sc_ff <= neg_ff ? -$signed({1'b0, r_sum}) : $signed({1'b0, r_sum});
               state_ff <= S_FIN;
            end
            S_FIN: begin
               col_ff <= '0;
               if (row_ff == IW'(N - 1)) begin
                  state_ff <= S_ROTATE;
               end else begin
                  row_ff <= row_ff + IW'(1);
                  state_ff <= S_MAC;
               end
            end
            S_ROTATE: begin
               tv_ff <= time_step_ff * steps_done_ff;
               node_ff <= '0;
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_step_ff <= steps_done_ff;
                  rsp_node_ff <= 4'(node_ff);
                  rsp_disp_ff <= sel_cur;
                  rsp_time_ff <= tv_ff;
                  rsp_status_ff <= sel_sat ? ewts_pkg::STATUS_SAT : ewts_pkg::STATUS_OK;
                  rsp_last_ff <= (node_ff == IW'(ewts_pkg::EMIT_COUNT - 1));
                  node_ff <= node_ff + IW'(1);
                  if (node_ff == IW'(ewts_pkg::EMIT_COUNT - 1)) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.step_number = rsp_step_ff;
   assign rsp_bus.node = rsp_node_ff;
   assign rsp_bus.displacement = rsp_disp_ff;
   assign rsp_bus.time_value = rsp_time_ff;
   assign rsp_bus.status = rsp_status_ff;
   assign rsp_bus.last = rsp_last_ff;

endmodule
